/* hdl/morse_beacon_keyer_top_assert.svh */
// ----------------------------------------------------------------------------
// Morse beacon keyer assertion macros
// Clocked property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MORSE_BEACON_KEYER_TOP_ASSERT_SVH
`define MORSE_BEACON_KEYER_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define MBK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define MBK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mbk_pkg.sv */
// ----------------------------------------------------------------------------
// Morse beacon keyer package
// Types, codes, register defaults and the symbol table shared by the keyer.
// ----------------------------------------------------------------------------
package mbk_pkg;

    localparam int MAX_CHARS_DEF    = 32;
    localparam int SYMBOLS_PER_CHAR = 8;
    localparam int SYM_W            = 3;
    localparam int TIME_W           = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CODE_W           = 5;
    localparam int NUM_ROWS         = 27;

    localparam logic [TIME_W-1:0] DOT_TIME_RST    = 16'd250;
    localparam logic [TIME_W-1:0] DASH_TIME_RST   = 16'd750;
    localparam logic [TIME_W-1:0] WORD_TIME_RST   = 16'd1750;
    localparam logic [TIME_W-1:0] START_DELAY_RST = 16'd100;

    localparam logic [7:0] ASCII_A          = 8'h41;
    localparam logic [7:0] ASCII_LETTER_END = 8'h41 + 8'd26;
    localparam logic [7:0] ASCII_SPACE      = 8'h20;
    localparam logic [CODE_W-1:0] WORD_ROW  = 5'd26;
    localparam logic [SYM_W-1:0] SYM_LAST   = 3'(SYMBOLS_PER_CHAR - 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_START  = 2'd1,
        OP_TICK   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOT_TIME    = 2'd0,
        CFG_DASH_TIME   = 2'd1,
        CFG_WORD_TIME   = 2'd2,
        CFG_START_DELAY = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        EL_DOT  = 3'd0,
        EL_DASH = 3'd1,
        EL_PAD  = 3'd2,
        EL_EGAP = 3'd3,
        EL_LGAP = 3'd4,
        EL_WGAP = 3'd5
    } elem_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] dot_len;
        logic [TIME_W-1:0] dash_len;
        logic [TIME_W-1:0] word_len;
        logic [TIME_W-1:0] start_delay;
    } cfg_t;

    typedef struct packed {
        logic append;
        logic start;
        logic dec_ticks;
        logic load_elem;
        logic skip_elem;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic playing;
        logic ticks_gt1;
        logic chars_left;
        logic elem_pad;
        logic sym_last;
        logic out_free;
    } status_t;

    // one nibble per element, first element in the top nibble
    localparam logic [31:0] SYM_ROWS [NUM_ROWS] = '{
        32'h0314_2222, 32'h1303_0304, 32'h1303_1304, 32'h1303_0422,
        32'h0422_2222, 32'h0303_1304, 32'h1313_0422, 32'h0303_0304,
        32'h0304_2222, 32'h0313_1314, 32'h1303_1422, 32'h0313_0304,
        32'h1314_2222, 32'h1304_2222, 32'h1313_1422, 32'h0313_1304,
        32'h1313_0314, 32'h0313_0422, 32'h0303_0422, 32'h1422_2222,
        32'h0303_1422, 32'h0303_0314, 32'h0313_1422, 32'h1303_0314,
        32'h1303_1314, 32'h1313_0304, 32'h2222_2225
    };

    function automatic elem_t sym_elem(input logic [CODE_W-1:0] row,
                                       input logic [SYM_W-1:0] col);
        logic [31:0] bits;
        logic [2:0]  code;
        bits = SYM_ROWS[row];
        code = bits[{~col, 2'b00} +: 3];
        return elem_t'(code);
    endfunction

endpackage

/* hdl/mbk_in_if.sv */
// ----------------------------------------------------------------------------
// Keyer request channel
// Valid/ready channel carrying one opcode and character per request.
// ----------------------------------------------------------------------------
interface mbk_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

/* hdl/mbk_out_if.sv */
// ----------------------------------------------------------------------------
// Keyer result channel
// Valid/ready channel carrying the keyed level and status of each request.
// ----------------------------------------------------------------------------
interface mbk_out_if;
    logic valid;
    logic ready;
    logic key_on;
    logic busy_res;
    logic rejected;
    logic finished;

    modport source (output valid, output key_on, output busy_res, output rejected,
                    output finished, input ready);
    modport sink   (input valid, input key_on, input busy_res, input rejected,
                    input finished, output ready);
endinterface

/* hdl/mbk_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Keyer timing registers
// Write-only timing registers, loaded from the configuration port.
// ----------------------------------------------------------------------------
module mbk_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mbk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbk_pkg::TIME_W-1:0]     cfg_data,
    output mbk_pkg::cfg_t                  cfg
);
    import mbk_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DOT_TIME:    cfg_next.dot_len     = cfg_data;
                CFG_DASH_TIME:   cfg_next.dash_len    = cfg_data;
                CFG_WORD_TIME:   cfg_next.word_len    = cfg_data;
                CFG_START_DELAY: cfg_next.start_delay = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_len     <= DOT_TIME_RST;
            cfg_reg.dash_len    <= DASH_TIME_RST;
            cfg_reg.word_len    <= WORD_TIME_RST;
            cfg_reg.start_delay <= START_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mbk_ctrl.sv */
// ----------------------------------------------------------------------------
// Keyer controller
// Sequences each request and walks the symbol table on element expiry.
// ----------------------------------------------------------------------------
module mbk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [1:0]        item_opcode,
    output logic              item_ready,
    input  mbk_pkg::status_t  status,
    output mbk_pkg::cmd_t     cmd
);
    import mbk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = (state_reg == S_IDLE) && status.out_free;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    case (opcode_t'(item_opcode))
                        OP_APPEND:
                        begin
                            cmd.append = 1'b1;
                            cmd.emit   = 1'b1;
                        end
                        OP_START:
                        begin
                            cmd.start = 1'b1;
                            cmd.emit  = 1'b1;
                        end
                        OP_TICK:
                        begin
                            if (!status.playing)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else if (status.ticks_gt1)
                            begin
                                cmd.dec_ticks = 1'b1;
                                cmd.emit      = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                if (!status.chars_left)
                begin
                    cmd.finish = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!status.elem_pad)
                begin
                    cmd.load_elem = 1'b1;
                    cmd.emit      = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.skip_elem = 1'b1;
                    if (status.sym_last)
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/mbk_datapath.sv */
// ----------------------------------------------------------------------------
// Keyer datapath
// Message store, playback position, element timer and result register.
// ----------------------------------------------------------------------------
module mbk_datapath #(
    parameter int MAX_CHARS = mbk_pkg::MAX_CHARS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        item_char_code,
    input  mbk_pkg::cfg_t     cfg,
    input  mbk_pkg::cmd_t     cmd,
    output mbk_pkg::status_t  status,
    input  logic              result_ready,
    output logic              result_valid,
    output logic              result_key_on,
    output logic              result_busy_res,
    output logic              result_rejected,
    output logic              result_finished
);
    import mbk_pkg::*;

    localparam int LEN_W = $clog2(MAX_CHARS + 1);
    localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

    logic [CODE_W-1:0] mem [MAX_CHARS];
    logic [CODE_W-1:0] rd_data_reg;

    logic [LEN_W-1:0]  length_reg,   length_next;
    logic [LEN_W-1:0]  char_pos_reg, char_pos_next;
    logic [SYM_W-1:0]  sym_pos_reg,  sym_pos_next;
    logic [TIME_W-1:0] ticks_reg,    ticks_next;
    logic              key_reg,      key_next;
    logic              playing_reg,  playing_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_key_reg,  res_busy_reg, res_rej_reg, res_fin_reg;

    logic              is_letter;
    logic              is_space;
    logic              append_ok;
    logic [7:0]        char_diff;
    logic [CODE_W-1:0] char_row;
    logic [CODE_W-1:0] row;
    elem_t             elem;
    logic              elem_key;
    logic [TIME_W-1:0] elem_ticks;
    logic              elem_pad;

    assign is_letter = (item_char_code >= ASCII_A) && (item_char_code < ASCII_LETTER_END);
    assign is_space  = (item_char_code == ASCII_SPACE);
    assign char_diff = item_char_code - ASCII_A;
    assign char_row  = is_space ? WORD_ROW : char_diff[CODE_W-1:0];
    assign append_ok = (is_letter || is_space) && !playing_reg
                       && (length_reg < LEN_W'(MAX_CHARS));

    assign row  = (rd_data_reg > WORD_ROW) ? WORD_ROW : rd_data_reg;
    assign elem = sym_elem(row, sym_pos_reg);

    always_comb
    begin
        elem_key   = 1'b0;
        elem_ticks = cfg.dot_len;
        elem_pad   = !(elem inside {EL_DOT, EL_DASH, EL_EGAP, EL_LGAP, EL_WGAP});
        case (elem)
            EL_DOT:
            begin
                elem_key   = 1'b1;
                elem_ticks = cfg.dot_len;
            end
            EL_DASH:
            begin
                elem_key   = 1'b1;
                elem_ticks = cfg.dash_len;
            end
            EL_EGAP: elem_ticks = cfg.dot_len;
            EL_LGAP: elem_ticks = cfg.dash_len;
            EL_WGAP: elem_ticks = cfg.word_len;
            default: elem_ticks = cfg.dot_len;
        endcase
    end

    always_comb
    begin
        length_next   = length_reg;
        char_pos_next = char_pos_reg;
        sym_pos_next  = sym_pos_reg;
        ticks_next    = ticks_reg;
        key_next      = key_reg;
        playing_next  = playing_reg;

        if (cmd.append && append_ok)
        begin
            length_next = length_reg + 1'b1;
        end
        if (cmd.start && !playing_reg && (length_reg != '0))
        begin
            playing_next  = 1'b1;
            char_pos_next = '0;
            sym_pos_next  = '0;
            key_next      = 1'b0;
            ticks_next    = cfg.start_delay;
        end
        if (cmd.dec_ticks)
        begin
            ticks_next = ticks_reg - 1'b1;
        end
        if (cmd.load_elem || cmd.skip_elem)
        begin
            sym_pos_next = sym_pos_reg + 1'b1;
            if (sym_pos_reg == SYM_LAST)
            begin
                char_pos_next = char_pos_reg + 1'b1;
            end
        end
        if (cmd.load_elem)
        begin
            key_next   = elem_key;
            ticks_next = elem_ticks;
        end
        if (cmd.finish)
        begin
            playing_next  = 1'b0;
            key_next      = 1'b0;
            ticks_next    = '0;
            length_next   = '0;
            char_pos_next = '0;
            sym_pos_next  = '0;
        end
    end

    assign res_valid_next = cmd.emit || (res_valid_reg && !result_ready);

    always_ff @(posedge clk)
    begin
        if (cmd.append && append_ok)
        begin
            mem[length_reg[AW-1:0]] <= char_row;
        end
        rd_data_reg <= mem[char_pos_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_key_reg  <= key_next;
            res_busy_reg <= playing_next;
            res_rej_reg  <= cmd.append && !append_ok;
            res_fin_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            char_pos_reg  <= '0;
            sym_pos_reg   <= '0;
            ticks_reg     <= '0;
            key_reg       <= 1'b0;
            playing_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            char_pos_reg  <= char_pos_next;
            sym_pos_reg   <= sym_pos_next;
            ticks_reg     <= ticks_next;
            key_reg       <= key_next;
            playing_reg   <= playing_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign status.playing    = playing_reg;
    assign status.ticks_gt1  = (ticks_reg > 16'd1);
    assign status.chars_left = (char_pos_reg < length_reg);
    assign status.elem_pad   = elem_pad;
    assign status.sym_last   = (sym_pos_reg == SYM_LAST);
    assign status.out_free   = !res_valid_reg || result_ready;

    assign result_valid    = res_valid_reg;
    assign result_key_on   = res_key_reg;
    assign result_busy_res = res_busy_reg;
    assign result_rejected = res_rej_reg;
    assign result_finished = res_fin_reg;

endmodule

/* hdl/morse_beacon_keyer_top.sv */
// ----------------------------------------------------------------------------
// Morse beacon keyer, top level
// Append, start and counting ticks: result registered in the cycle after acceptance.
// A tick that ends an element walks the symbol table one entry per cycle, with
// a registered store read in the FETCH state per character. One request at a time.
// Reset clears playback state and restores default timings; store undefined.
// ----------------------------------------------------------------------------
module morse_beacon_keyer_top #(
    parameter int MAX_CHARS = mbk_pkg::MAX_CHARS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mbk_in_if.sink                         item,
    mbk_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [mbk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbk_pkg::TIME_W-1:0]     cfg_data
);
    import mbk_pkg::*;

    `include "morse_beacon_keyer_top_assert.svh"

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    mbk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbk_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_opcode (item.opcode),
        .item_ready  (item.ready),
        .status      (status),
        .cmd         (cmd)
    );

    mbk_datapath #(
        .MAX_CHARS (MAX_CHARS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_char_code  (item.char_code),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .result_ready    (result.ready),
        .result_valid    (result.valid),
        .result_key_on   (result.key_on),
        .result_busy_res (result.busy_res),
        .result_rejected (result.rejected),
        .result_finished (result.finished)
    );

    `MBK_ASSERT_NOW(a_key_needs_busy, clk, rst_n, result.valid && result.key_on, result.busy_res, "carrier keyed outside playback")
    `MBK_ASSERT_NOW(a_finish_idle, clk, rst_n, result.valid && result.finished, !result.busy_res && !result.rejected, "finish result not idle")
    `MBK_ASSERT_NEXT(a_append_answer, clk, rst_n, item.valid && item.ready && item.opcode == OP_APPEND, result.valid && !result.finished, "append request not answered next cycle")
    `MBK_ASSERT_NOW(a_scan_blocks, clk, rst_n, cmd.skip_elem || cmd.load_elem || cmd.finish, !item.ready, "request taken during table walk")

endmodule
